/* hdl/ttte_pkg.sv */
// ----------------------------------------------------------------------------
// ttte_pkg
// Shared types and codes of the timer table tick engine.
// ----------------------------------------------------------------------------
package ttte_pkg;

  // table depth default
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // field widths
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned HANDLE_W      = 8;
  localparam int unsigned TICKS_W       = 32;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // command codes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_COUNT  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // one table entry
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  remaining;
    logic [TICKS_W-1:0]  reload;
    logic                periodic;
    logic                active;
    logic                notify;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load;      // take the added entry
    logic shift;     // take the entry of the next cell up
    logic tick;      // count down this entry
    logic ev_shift;  // move the expiry flags one place down
  } cell_ctl_t;

  // latched request
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [HANDLE_W-1:0] timer_handle;
    logic [TICKS_W-1:0]  start_count;
    logic [TICKS_W-1:0]  reload_period;
    logic                periodic;
    logic                active;
    logic                notify;
  } req_t;

  // one result
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     ok;
    logic [HANDLE_W-1:0]      expired_handle;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;
  } res_t;

endpackage

/* hdl/ttte_req_if.sv */
// ----------------------------------------------------------------------------
// ttte_req_if
// Request channel of the timer table: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface ttte_req_if;
  logic                             valid;
  logic                             ready;
  logic [ttte_pkg::OPCODE_W-1:0]    opcode;
  logic [ttte_pkg::HANDLE_W-1:0]    timer_handle;
  logic [ttte_pkg::TICKS_W-1:0]     start_count;
  logic [ttte_pkg::TICKS_W-1:0]     reload_period;
  logic                             periodic;
  logic                             active;
  logic                             notify;

  modport source (
    output valid, opcode, timer_handle, start_count, reload_period,
           periodic, active, notify,
    input  ready
  );

  modport sink (
    input  valid, opcode, timer_handle, start_count, reload_period,
           periodic, active, notify,
    output ready
  );
endinterface

/* hdl/ttte_res_if.sv */
// ----------------------------------------------------------------------------
// ttte_res_if
// Result channel of the timer table: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface ttte_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [ttte_pkg::KIND_W-1:0]          kind;
  logic                                 ok;
  logic [ttte_pkg::HANDLE_W-1:0]        expired_handle;
  logic [ttte_pkg::ENTRY_COUNT_W-1:0]   entry_count;
  logic                                 last;

  modport source (
    output valid, kind, ok, expired_handle, entry_count, last,
    input  ready
  );

  modport sink (
    input  valid, kind, ok, expired_handle, entry_count, last,
    output ready
  );
endinterface

/* hdl/ttte_cell.sv */
// ----------------------------------------------------------------------------
// ttte_cell
// One table slot: holds an entry, counts it down on a tick, and carries an
// expiry flag that moves down the row towards the output.
// ----------------------------------------------------------------------------
module ttte_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttte_pkg::cell_ctl_t           ctl_i,
  input  ttte_pkg::entry_t              add_i,
  input  ttte_pkg::entry_t              nbr_i,
  input  logic                          nbr_ev_i,
  input  logic [ttte_pkg::HANDLE_W-1:0] nbr_ev_handle_i,
  output ttte_pkg::entry_t              entry_o,
  output logic                          ev_o,
  output logic [ttte_pkg::HANDLE_W-1:0] ev_handle_o
);

  ttte_pkg::entry_t              entry_q, entry_d;
  logic                          ev_q, ev_d;
  logic [ttte_pkg::HANDLE_W-1:0] ev_handle_q, ev_handle_d;
  logic [ttte_pkg::TICKS_W-1:0]  dec;

  // count down, saturating at zero
  assign dec = (entry_q.remaining != '0) ? entry_q.remaining - 1'b1
                                         : entry_q.remaining;

  // next entry and expiry flag
  always_comb begin
    entry_d     = entry_q;
    ev_d        = ev_q;
    ev_handle_d = ev_handle_q;
    if (ctl_i.load) begin
      entry_d = add_i;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end else if (ctl_i.tick) begin
      ev_d = 1'b0;
      if (entry_q.active) begin
        entry_d.remaining = dec;
        if (dec == '0) begin
          ev_d        = entry_q.notify;
          ev_handle_d = entry_q.handle;
          if (entry_q.periodic) begin
            entry_d.remaining = entry_q.reload;
          end else begin
            entry_d.active = 1'b0;
          end
        end
      end
    end
    if (ctl_i.ev_shift) begin
      ev_d        = nbr_ev_i;
      ev_handle_d = nbr_ev_handle_i;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    entry_q     <= entry_d;
    ev_handle_q <= ev_handle_d;
  end

  // expiry flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else begin
      ev_q <= ev_d;
    end
  end

  assign entry_o     = entry_q;
  assign ev_o        = ev_q;
  assign ev_handle_o = ev_handle_q;

endmodule

/* hdl/timer_table_tick_engine.sv */
// ----------------------------------------------------------------------------
// timer_table_tick_engine
// Ordered table of timer entries held in a row of cells, with add, remove,
// count and tick commands.
// ----------------------------------------------------------------------------
// The table is a row of MAX_ENTRIES cells, entry 0 at the bottom. One request
// is worked on at a time; the request port is ready whenever the previous
// request has handed its final result to the output register, which may still
// be waiting to be taken. Add, remove and count first latch the request; then,
// once the result slot is free, every cell acts at once (an add writes the
// slot at the fill count, a remove finds the first matching handle along the
// row and moves every later cell down one place). A tick counts the active
// entries of all filled cells down at once and flags those that expire with
// notify set; the flags then move down the row one place per cycle, unless an
// expiry at cell 0 waits for the result slot, and each one reaching cell 0 is
// sent as an expiry, followed by the done result.
module timer_table_tick_engine #(
  parameter int unsigned MAX_ENTRIES = ttte_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ttte_req_if.sink      req_i,
  ttte_res_if.source    res_o
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  ttte_pkg::req_t         req_q;
  ttte_pkg::res_t         res_q, res_d;
  logic                   res_valid_q;
  logic                   res_load;
  logic                   res_free;
  logic                   req_fire;

  ttte_pkg::entry_t       add_entry;
  ttte_pkg::cell_ctl_t    ctl [MAX_ENTRIES];
  ttte_pkg::entry_t       entry [MAX_ENTRIES];
  ttte_pkg::entry_t       nbr [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] ev;
  logic [MAX_ENTRIES-1:0] nbr_ev;
  logic [ttte_pkg::HANDLE_W-1:0] ev_handle [MAX_ENTRIES];
  logic [ttte_pkg::HANDLE_W-1:0] nbr_ev_handle [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES:0]   seen;

  // request handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.opcode        <= req_i.opcode;
      req_q.timer_handle  <= req_i.timer_handle;
      req_q.start_count   <= req_i.start_count;
      req_q.reload_period <= req_i.reload_period;
      req_q.periodic      <= req_i.periodic;
      req_q.active        <= req_i.active;
      req_q.notify        <= req_i.notify;
    end
  end

  // entry written by an add
  always_comb begin
    add_entry.handle    = req_q.timer_handle;
    add_entry.remaining = req_q.start_count;
    add_entry.reload    = req_q.reload_period;
    add_entry.periodic  = req_q.periodic;
    add_entry.active    = req_q.active;
    add_entry.notify    = req_q.notify;
  end

  // row of cells, each fed by the one above it
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign valid[i]   = (CW'(i) < count_q);
    assign match[i]   = valid[i] && (entry[i].handle == req_q.timer_handle);
    assign seen[i+1]  = seen[i] | match[i];

    if (i + 1 < MAX_ENTRIES) begin : g_nbr
      assign nbr[i]           = entry[i+1];
      assign nbr_ev[i]        = ev[i+1];
      assign nbr_ev_handle[i] = ev_handle[i+1];
    end else begin : g_top
      assign nbr[i]           = entry[i];
      assign nbr_ev[i]        = 1'b0;
      assign nbr_ev_handle[i] = '0;
    end

    ttte_cell u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctl_i           (ctl[i]),
      .add_i           (add_entry),
      .nbr_i           (nbr[i]),
      .nbr_ev_i        (nbr_ev[i]),
      .nbr_ev_handle_i (nbr_ev_handle[i]),
      .entry_o         (entry[i]),
      .ev_o            (ev[i]),
      .ev_handle_o     (ev_handle[i])
    );
  end

  // result slot is free when empty or being taken
  assign res_free = !res_valid_q || res_o.ready;

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    res_load = 1'b0;
    res_d    = res_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl[i] = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (req_q.opcode == ttte_pkg::OP_TICK) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctl[i].tick = valid[i];
          end
          state_d = ST_EMIT;
        end else if (res_free) begin
          res_d.kind           = ttte_pkg::KIND_STATUS;
          res_d.ok             = 1'b1;
          res_d.expired_handle = '0;
          res_d.last           = 1'b1;
          case (req_q.opcode)
            ttte_pkg::OP_ADD: begin
              if (count_q < CW'(MAX_ENTRIES)) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                  ctl[i].load = (count_q == CW'(i));
                end
                count_d = count_q + 1'b1;
              end else begin
                res_d.ok = 1'b0;
              end
            end
            ttte_pkg::OP_REMOVE: begin
              if (seen[MAX_ENTRIES]) begin
                // first match is overwritten and everything above it moves down one place
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                  ctl[i].shift = valid[i] && seen[i+1];
                end
                count_d = count_q - 1'b1;
              end else begin
                res_d.ok = 1'b0;
              end
            end
            default: begin
            end
          endcase
          res_d.entry_count = ttte_pkg::ENTRY_COUNT_W'(count_d);
          res_load          = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_EMIT: begin
        res_d.ok          = 1'b1;
        res_d.entry_count = ttte_pkg::ENTRY_COUNT_W'(count_q);
        if (ev[0]) begin
          // expiry at the bottom of the row goes out, then the flags move down
          if (res_free) begin
            res_d.kind           = ttte_pkg::KIND_EXPIRY;
            res_d.expired_handle = ev_handle[0];
            res_d.last           = 1'b0;
            res_load             = 1'b1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              ctl[i].ev_shift = 1'b1;
            end
          end
        end else if (|ev) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctl[i].ev_shift = 1'b1;
          end
        end else if (res_free) begin
          res_d.kind           = ttte_pkg::KIND_DONE;
          res_d.expired_handle = '0;
          res_d.last           = 1'b1;
          res_load             = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.kind           = res_q.kind;
  assign res_o.ok             = res_q.ok;
  assign res_o.expired_handle = res_q.expired_handle;
  assign res_o.entry_count    = res_q.entry_count;
  assign res_o.last           = res_q.last;

endmodule
